// ===== rtl/core/tlbl_pkg.sv =====
// Shared types and constants for the TLB lookup block.
`timescale 1ns / 1ps

package tlbl_pkg;

  localparam int MaxEntries = 16;
  localparam int NumBits    = 20;
  localparam int IdxW       = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int CntW       = $clog2(MaxEntries + 1);

  // Configuration port.
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 5;
  localparam logic [CfgIdxW-1:0] CfgReplaceMode  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgEntriesInUse = 2'd1;

  localparam logic              ModeFifo        = 1'b0;
  localparam logic              ModeLru         = 1'b1;
  localparam logic [CfgDataW-1:0] EntriesInUseRst = 5'd16;

  typedef enum logic [1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_FLUSH  = 2'd2,
    KIND_INVAL  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [NumBits-1:0] page;
    logic [NumBits-1:0] frame;
  } tlbl_req_t;

  typedef struct packed {
    logic               hit;
    logic [NumBits-1:0] frame_out;
    logic               evicted;
    logic [NumBits-1:0] evicted_page;
  } tlbl_rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;
    logic do_search;
    logic do_update;
  } tlbl_cmd_t;

endpackage

// ===== rtl/core/tlb_lookup_fifo_lru_unit.sv =====
// Top level of the fully associative TLB with FIFO or LRU ordering.
`timescale 1ns / 1ps
//
//  Channel  | Direction | Handshake            | Payload
//  ---------+-----------+----------------------+--------------------------------
//  in       | input     | in_valid_i/in_stall_o| in_req_i  (kind, page, frame)
//  out      | output    | out_valid_o/out_stall_i | out_rsp_o (hit, frame_out,
//           |           |                      |   evicted, evicted_page)
//  cfg      | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
//  Each transaction runs a search step that compares all entries and picks the
//  oldest match, then an update step that shifts the age order and loads the
//  result register. The next transaction is taken in the update cycle, so a new
//  request overlaps the update of the last one; the update cycle waits while the
//  result register still holds an untaken result.
//  Reset empties the table (count only), selects FIFO and a capacity of 16.
//  A write to the configuration port completes in the cycle it is offered.

module tlb_lookup_fifo_lru_unit
  import tlbl_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // request channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tlbl_req_t           in_req_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tlbl_rsp_t           out_rsp_o,
  // configuration channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  tlbl_cmd_t cmd;

  // Configuration registers never back-pressure.
  assign cfg_ready_o = 1'b1;

  // Sequence accept, search and update; hold the result valid until taken.
  tlbl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Entries, match logic, age-order shifter and result register.
  tlbl_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_req_i    (in_req_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .rsp_o       (out_rsp_o)
  );

endmodule

// ===== rtl/core/tlbl_ctrl.sv =====
// Sequencing state machine for the TLB lookup block.
`timescale 1ns / 1ps

module tlbl_ctrl
  import tlbl_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output tlbl_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_UPDATE = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free, update_go, accept;

  assign slot_free  = !out_valid_q || !out_stall_i;
  assign update_go  = (state_q == S_UPDATE) && slot_free;
  assign in_stall_o = !((state_q == S_IDLE) || update_go);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_SEARCH;
      end
      S_SEARCH: begin
        state_d = S_UPDATE;
      end
      S_UPDATE: begin
        if (slot_free) state_d = accept ? S_SEARCH : S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (update_go) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign cmd_o.load_req  = accept;
  assign cmd_o.do_search = (state_q == S_SEARCH);
  assign cmd_o.do_update = update_go;

  a_search_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH) |-> in_stall_o)
    else $error("input taken during search");

  a_result_from_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_UPDATE))
    else $error("result raised outside update");

  a_accept_starts_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_SEARCH))
    else $error("accepted transaction not searched");

endmodule

// ===== rtl/core/tlbl_dp.sv =====
// Entry storage, match logic, age-order shifter and result register.
`timescale 1ns / 1ps

module tlbl_dp
  import tlbl_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tlbl_cmd_t           cmd_i,
  input  tlbl_req_t           in_req_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output tlbl_rsp_t           rsp_o
);

  logic [NumBits-1:0] page_q  [MaxEntries];
  logic [NumBits-1:0] frame_q [MaxEntries];
  logic [NumBits-1:0] page_up [MaxEntries];
  logic [NumBits-1:0] frame_up[MaxEntries];
  logic [CntW-1:0]    count_q, count_d;
  logic               mode_q;
  logic [CfgDataW-1:0] cap_raw_q;
  logic [CntW-1:0]    cap;

  tlbl_req_t          req_q;
  tlbl_rsp_t          rsp_q, rsp_d;
  logic               found_q, found_c;
  logic [IdxW-1:0]    idx_q, idx_c;
  logic [NumBits-1:0] hit_frame_q;
  logic [MaxEntries-1:0] sel;

  logic               shift_en, wr_en;
  logic [IdxW-1:0]    shift_from, wr_pos;
  logic [NumBits-1:0] wr_page, wr_frame;
  logic [CntW-1:0]    count_m1;
  logic               full;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= ModeFifo;
      cap_raw_q <= EntriesInUseRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgReplaceMode:  mode_q    <= cfg_data_i[0];
        CfgEntriesInUse: cap_raw_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp capacity to 1..MaxEntries.
  always_comb begin
    if (cap_raw_q == '0) begin
      cap = CntW'(1);
    end else if (int'(cap_raw_q) > MaxEntries) begin
      cap = CntW'(MaxEntries);
    end else begin
      cap = CntW'(cap_raw_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) req_q <= in_req_i;
  end

  // Match vector: page for lookups, frame for invalidates.
  always_comb begin
    for (int i = 0; i < MaxEntries; i++) begin
      if (req_q.kind == KIND_INVAL) begin
        sel[i] = (CntW'(i) < count_q) && (frame_q[i] == req_q.frame);
      end else begin
        sel[i] = (CntW'(i) < count_q) && (page_q[i] == req_q.page);
      end
    end
  end

  // Oldest match wins.
  always_comb begin
    found_c = 1'b0;
    idx_c   = '0;
    for (int i = MaxEntries - 1; i >= 0; i--) begin
      if (sel[i]) begin
        found_c = 1'b1;
        idx_c   = IdxW'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_search) begin
      found_q     <= found_c;
      idx_q       <= idx_c;
      hit_frame_q <= frame_q[idx_c];
    end
  end

  assign count_m1 = count_q - CntW'(1);
  assign full     = (count_q >= cap) && (count_q != '0);

  // Decide the order update and the result.
  always_comb begin
    shift_en   = 1'b0;
    shift_from = '0;
    wr_en      = 1'b0;
    wr_pos     = count_m1[IdxW-1:0];
    wr_page    = req_q.page;
    wr_frame   = req_q.frame;
    count_d    = count_q;
    rsp_d      = '0;
    case (req_q.kind)
      KIND_LOOKUP: begin
        rsp_d.hit = found_q;
        if (found_q) begin
          rsp_d.frame_out = hit_frame_q;
          if (mode_q == ModeLru) begin
            // Move the hit entry to the youngest slot.
            shift_en   = 1'b1;
            shift_from = idx_q;
            wr_en      = 1'b1;
            wr_frame   = hit_frame_q;
          end
        end
      end
      KIND_INSERT: begin
        if (full) begin
          rsp_d.evicted      = 1'b1;
          rsp_d.evicted_page = page_q[0];
          shift_en           = 1'b1;
          wr_en              = 1'b1;
        end else if (count_q < CntW'(MaxEntries)) begin
          wr_en   = 1'b1;
          wr_pos  = count_q[IdxW-1:0];
          count_d = count_q + CntW'(1);
        end
      end
      KIND_FLUSH: begin
        count_d = '0;
      end
      default: begin
        if (found_q) begin
          shift_en   = 1'b1;
          shift_from = idx_q;
          count_d    = count_m1;
        end
      end
    endcase
  end

  // Younger neighbor of each slot; the last slot has none.
  for (genvar k = 0; k < MaxEntries; k++) begin : g_up
    if (k < MaxEntries - 1) begin : g_mid
      assign page_up[k]  = page_q[k+1];
      assign frame_up[k] = frame_q[k+1];
    end else begin : g_top
      assign page_up[k]  = page_q[k];
      assign frame_up[k] = frame_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_update) begin
      for (int k = 0; k < MaxEntries; k++) begin
        if (wr_en && (wr_pos == IdxW'(k))) begin
          page_q[k]  <= wr_page;
          frame_q[k] <= wr_frame;
        end else if (shift_en && (IdxW'(k) >= shift_from) &&
                     (CntW'(k + 1) < count_q)) begin
          page_q[k]  <= page_up[k];
          frame_q[k] <= frame_up[k];
        end
      end
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.do_update) begin
      count_q <= count_d;
    end
  end

  assign rsp_o = rsp_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxEntries))
    else $error("entry count above table size");

  a_flush_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.do_update && (req_q.kind == KIND_FLUSH)) |=> (count_q == '0))
    else $error("flush left entries");

endmodule

// ===== tb/tlb_lookup_fifo_lru_unit_tb.sv =====
// Self-checking testbench for the FIFO/LRU translation lookaside buffer.
`timescale 1ns / 1ps

import tlbl_pkg::*;

// Tracks the table contents and the register settings, predicts the result of
// every accepted request, and checks each result against the oldest prediction.
class tlb_scoreboard;
  logic                replace_lru;
  logic [CfgDataW-1:0] cap_setting;
  logic [NumBits-1:0]  page_tab[MaxEntries];
  logic [NumBits-1:0]  frame_tab[MaxEntries];
  int                  used;
  tlbl_rsp_t           rsp_q[$];
  int                  errors, n_lookups, n_hits, n_inserts, n_evicts, n_flushes, n_invals;

  function new();
    replace_lru = ModeFifo;
    cap_setting = EntriesInUseRst;
    used        = 0;
    errors      = 0;
    n_lookups   = 0;
    n_hits      = 0;
    n_inserts   = 0;
    n_evicts    = 0;
    n_flushes   = 0;
    n_invals    = 0;
  endfunction

  function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    if (idx == CfgReplaceMode) replace_lru = data[0];
    else if (idx == CfgEntriesInUse) cap_setting = data;
  endfunction

  // Zero counts as one slot; anything above the table size saturates.
  function int capacity();
    if (cap_setting == '0) return 1;
    if (cap_setting > MaxEntries) return MaxEntries;
    return int'(cap_setting);
  endfunction

  // Close the gap left by position pos; younger entries shift toward oldest.
  function void remove_at(int pos);
    for (int k = pos; k + 1 < used; k++) begin
      page_tab[k]  = page_tab[k + 1];
      frame_tab[k] = frame_tab[k + 1];
    end
    used--;
  endfunction

  function void append(logic [NumBits-1:0] pg, logic [NumBits-1:0] fr);
    if (used < MaxEntries) begin
      page_tab[used]  = pg;
      frame_tab[used] = fr;
      used++;
    end
  endfunction

  function void note_request(tlbl_req_t req);
    tlbl_rsp_t          exp;
    logic [NumBits-1:0] fr;
    exp = '0;
    case (req.kind)
      KIND_LOOKUP: begin
        n_lookups++;
        for (int i = 0; i < used; i++) begin
          if (page_tab[i] == req.page) begin
            fr            = frame_tab[i];
            exp.hit       = 1'b1;
            exp.frame_out = fr;
            n_hits++;
            if (replace_lru == ModeLru) begin
              remove_at(i);
              append(req.page, fr);
            end
            break;
          end
        end
      end
      KIND_INSERT: begin
        n_inserts++;
        // Only the single oldest entry goes, even when the limit was lowered
        // below the current count.
        if (used >= capacity() && used > 0) begin
          exp.evicted      = 1'b1;
          exp.evicted_page = page_tab[0];
          remove_at(0);
          n_evicts++;
        end
        append(req.page, req.frame);
      end
      KIND_FLUSH: begin
        n_flushes++;
        used = 0;
      end
      default: begin
        n_invals++;
        for (int i = 0; i < used; i++) begin
          if (frame_tab[i] == req.frame) begin
            remove_at(i);
            break;
          end
        end
      end
    endcase
    rsp_q.push_back(exp);
  endfunction

  function void compare_field(string name, logic [NumBits-1:0] exp, logic [NumBits-1:0] act);
    if (exp !== act) begin
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, exp, act);
      errors++;
    end
  endfunction

  function void check_result(tlbl_rsp_t got);
    tlbl_rsp_t exp;
    if (rsp_q.size() == 0) begin
      $display("%0t ns: result %h arrived with no request outstanding", $time, got);
      errors++;
      return;
    end
    exp = rsp_q.pop_front();
    compare_field("hit", NumBits'(exp.hit), NumBits'(got.hit));
    compare_field("frame_out", exp.frame_out, got.frame_out);
    compare_field("evicted", NumBits'(exp.evicted), NumBits'(got.evicted));
    compare_field("evicted_page", exp.evicted_page, got.evicted_page);
  endfunction

  function int pending();
    return rsp_q.size();
  endfunction
endclass

module tlb_lookup_fifo_lru_unit_tb;

  // Register indexes beyond the defined ones; writes to them must be dropped.
  localparam logic [CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 2'd3;

  localparam int PoolSize      = 12;
  localparam int NumPhases     = 9;
  localparam int ItemsPerPhase = 150;
  localparam int DrainCycles   = 4;

  // Receiver behavior for one stretch of cycles.
  typedef enum logic [1:0] {
    RX_FREE,
    RX_LIGHT,
    RX_HEAVY,
    RX_HOLD
  } rx_mode_e;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  tlbl_req_t           in_req_i    = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  tlbl_rsp_t           out_rsp_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  tlb_scoreboard sb = new();

  // Sender burst bookkeeping.
  int burst_left = 0;
  int n_settings = 0;

  // Receiver stall pattern state.
  rx_mode_e rx_mode    = RX_FREE;
  int       rx_left    = 0;
  int       rx_epoch   = 0;
  int       n_holdoffs = 0;

  // Small pools of pages and frames so that lookups hit, duplicates occur and
  // invalidates find their frame; the rest of the values are fully random.
  logic [NumBits-1:0] page_pool[PoolSize];
  logic [NumBits-1:0] frame_pool[PoolSize];

  // Register settings for the random phases: both policies, a zero capacity,
  // a capacity of one, the table size and values above it.
  logic                mode_plan[NumPhases] = '{ModeLru, ModeFifo, ModeLru, ModeFifo, ModeLru,
                                                ModeFifo, ModeLru, ModeFifo, ModeLru};
  logic [CfgDataW-1:0] cap_plan[NumPhases]  = '{5'd16, 5'd4, 5'd0, 5'd31, 5'd3,
                                                5'd16, 5'd7, 5'd1, 5'd20};

  tlb_lookup_fifo_lru_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Offer one request and hold it until the block takes it. Between bursts of
  // random length drop valid for a random number of cycles, so that gaps land
  // on both steps of the block's compare/update sequence.
  task automatic send_req(tlbl_req_t req);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    // Values read right at the edge are the ones the block saw before it.
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(req);
    burst_left--;
  endtask

  task automatic send(kind_e kind, logic [NumBits-1:0] pg, logic [NumBits-1:0] fr);
    tlbl_req_t req;
    req.kind  = kind;
    req.page  = pg;
    req.frame = fr;
    send_req(req);
  endtask

  // Stop offering and wait until every predicted result has been taken, then
  // give the block a few more cycles to settle before touching registers.
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Keep valid high across consecutive writes; the caller lowers it.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
  endtask

  // Program both registers, plus one write to an unused index that must have
  // no effect. Upper data bits of the mode write are random.
  task automatic program_regs(logic mode, logic [CfgDataW-1:0] cap);
    logic [CfgDataW-1:0] mode_word;
    logic [CfgDataW-1:0] junk;
    mode_word    = CfgDataW'($urandom_range(0, 2**CfgDataW - 1));
    mode_word[0] = mode;
    junk         = CfgDataW'($urandom_range(0, 2**CfgDataW - 1));
    write_reg(($urandom_range(0, 1) == 0) ? CfgSpareA : CfgSpareB, junk);
    write_reg(CfgEntriesInUse, cap);
    write_reg(CfgReplaceMode, mode_word);
    cfg_valid_i <= 1'b0;
    n_settings++;
  endtask

  // Mostly lookups and inserts; flushes are rare so the table gets to fill up.
  function automatic tlbl_req_t make_req();
    tlbl_req_t req;
    int        pick;
    pick = $urandom_range(0, 99);
    if (pick < 47) req.kind = KIND_LOOKUP;
    else if (pick < 83) req.kind = KIND_INSERT;
    else if (pick < 85) req.kind = KIND_FLUSH;
    else req.kind = KIND_INVAL;
    if ($urandom_range(0, 99) < 80) req.page = page_pool[$urandom_range(0, PoolSize - 1)];
    else req.page = NumBits'($urandom_range(0, 2**NumBits - 1));
    if ($urandom_range(0, 99) < 65) req.frame = frame_pool[$urandom_range(0, PoolSize - 1)];
    else req.frame = NumBits'($urandom_range(0, 2**NumBits - 1));
    return req;
  endfunction

  // Receiver: take and check results, and drive stall from a pattern of its
  // own. Each stretch picks free running, light or heavy random stalls; every
  // sixth stretch is a long hold-off that backs the block up into its input.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_rsp_o);
    if (rx_left == 0) begin
      rx_epoch++;
      if (rx_epoch % 6 == 0) begin
        rx_mode = RX_HOLD;
        rx_left = $urandom_range(40, 80);
        n_holdoffs++;
      end else begin
        rx_mode = rx_mode_e'($urandom_range(0, 2));
        rx_left = $urandom_range(10, 120);
      end
    end
    rx_left--;
    case (rx_mode)
      RX_FREE:  out_stall_i <= 1'b0;
      RX_LIGHT: out_stall_i <= ($urandom_range(0, 99) < 25);
      RX_HEAVY: out_stall_i <= ($urandom_range(0, 99) < 70);
      default:  out_stall_i <= 1'b1;
    endcase
  end

  initial begin
    page_pool[0]  = '0;
    page_pool[1]  = '1;
    frame_pool[0] = '0;
    frame_pool[1] = '1;
    for (int i = 2; i < PoolSize; i++) begin
      page_pool[i]  = NumBits'($urandom_range(0, 2**NumBits - 1));
      frame_pool[i] = NumBits'($urandom_range(0, 2**NumBits - 1));
    end

    // Hold reset, then release it at a rising edge.
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, extreme pages and frames, a duplicate page,
    // misses and an invalidate that matches nothing. Reset settings apply.
    send(KIND_LOOKUP, '0, '0);            // miss on an empty table
    send(KIND_FLUSH,  '1, '1);            // flush of an empty table
    send(KIND_INVAL,  '1, '0);            // invalidate on an empty table
    send(KIND_INSERT, '0, '1);
    send(KIND_INSERT, '1, '0);
    send(KIND_INSERT, '0, 20'h5a5a5);     // same page again, younger
    send(KIND_LOOKUP, '0, '0);            // oldest duplicate wins
    send(KIND_LOOKUP, '1, '1);
    send(KIND_LOOKUP, 20'h12345, '0);     // miss
    send(KIND_INVAL,  '0, 20'h77777);     // no frame matches
    send(KIND_INVAL,  '0, '1);            // drop the oldest duplicate
    send(KIND_LOOKUP, '0, '0);            // now the younger duplicate answers
    send(KIND_FLUSH,  '0, '0);
    send(KIND_LOOKUP, '1, '0);            // miss after flush

    // LRU with room for two: a hit protects its entry from eviction.
    drain();
    program_regs(ModeLru, 5'd2);
    send(KIND_INSERT, 20'h00001, 20'h00011);
    send(KIND_INSERT, 20'h00002, 20'h00022);
    send(KIND_LOOKUP, 20'h00001, '0);
    send(KIND_INSERT, 20'h00003, 20'h00033);   // evicts page 2
    send(KIND_LOOKUP, 20'h00002, '0);

    // Zero capacity acts as one, and it sits below the two entries held: each
    // insert evicts just the oldest and the count stays put.
    drain();
    program_regs(ModeFifo, 5'd0);
    send(KIND_INSERT, 20'h00004, 20'h00044);
    send(KIND_INSERT, 20'h00005, 20'h00055);
    send(KIND_LOOKUP, 20'h00004, '0);

    // Random phases, one register setting each. The table is not flushed
    // between phases, so lowered capacities meet fuller tables.
    for (int ph = 0; ph < NumPhases; ph++) begin
      drain();
      program_regs(mode_plan[ph], cap_plan[ph]);
      repeat (ItemsPerPhase) send_req(make_req());
    end

    drain();
    repeat (10) @(posedge clk_i);

    $display("Covered %0d lookups (%0d hits), %0d inserts (%0d evictions),",
             sb.n_lookups, sb.n_hits, sb.n_inserts, sb.n_evicts);
    $display("%0d flushes, %0d frame invalidates across %0d register settings",
             sb.n_flushes, sb.n_invals, n_settings);
    $display("with %0d long output hold-offs; %0d mismatches", n_holdoffs, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** tlb_lookup_fifo_lru_unit: PASSED **");
    end else begin
      $display("** tlb_lookup_fifo_lru_unit: FAILED **");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("Timeout with %0d results still outstanding", sb.pending());
    $display("** tlb_lookup_fifo_lru_unit: FAILED **");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/tlbl_pkg.sv
rtl/core/tlbl_ctrl.sv
rtl/core/tlbl_dp.sv
rtl/core/tlb_lookup_fifo_lru_unit.sv
tb/tlb_lookup_fifo_lru_unit_tb.sv
